// File: rtl/dhc_pkg.sv
package dhc_pkg;

    // Default store depth: centres kept per track
    localparam int TRACK_DEPTH_DEF = 256;

    // Field widths
    localparam int BOX_W    = 12;
    localparam int CTR_W    = 14;   // doubled (half-pixel) centre
    localparam int HOT_W    = 13;
    localparam int RADIUS_W = 8;
    localparam int COUNT_W  = 9;

    localparam logic [COUNT_W-1:0]  COUNT_MAX     = {COUNT_W{1'b1}};
    localparam logic [RADIUS_W-1:0] RADIUS_RST    = RADIUS_W'(50);
    localparam logic [COUNT_W-1:0]  MIN_COUNT_RST = COUNT_W'(125);   // 25 fps times 5 s

    // APB register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_RADIUS    = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_MIN_COUNT = 3'd4;

    // Query travelling down the cell chain
    typedef struct packed {
        logic [CTR_W-1:0]   cx2;
        logic [CTR_W-1:0]   cy2;
        logic [COUNT_W-1:0] count;
        logic               overflow;
    } probe_t;

endpackage

// File: rtl/dhc_cell.sv
module dhc_cell #(
    parameter int FILL_W     = 9,
    parameter int CELL_INDEX = 0
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            advance,
    input  logic                            wr_en,
    input  logic [dhc_pkg::CTR_W-1:0]       wr_cx2,
    input  logic [dhc_pkg::CTR_W-1:0]       wr_cy2,
    input  logic [dhc_pkg::RADIUS_W:0]      lim,
    input  logic                            valid_in,
    input  dhc_pkg::probe_t                 probe_in,
    input  logic [FILL_W-1:0]               fill_in,
    output logic                            valid_out,
    output dhc_pkg::probe_t                 probe_out,
    output logic [FILL_W-1:0]               fill_out
);

    logic [dhc_pkg::CTR_W-1:0] sx_reg;
    logic [dhc_pkg::CTR_W-1:0] sy_reg;
    logic                      valid_reg;
    dhc_pkg::probe_t           probe_reg;
    dhc_pkg::probe_t           probe_next;
    logic [FILL_W-1:0]         fill_reg;
    logic [dhc_pkg::CTR_W-1:0] dx;
    logic [dhc_pkg::CTR_W-1:0] dy;
    logic                      live;
    logic                      hit;

    // Entry is live only if it lies below the fill level seen by this query
    assign live = FILL_W'(CELL_INDEX) < fill_in;
    assign dx   = (probe_in.cx2 >= sx_reg) ? probe_in.cx2 - sx_reg : sx_reg - probe_in.cx2;
    assign dy   = (probe_in.cy2 >= sy_reg) ? probe_in.cy2 - sy_reg : sy_reg - probe_in.cy2;
    assign hit  = live
                  && (dx < dhc_pkg::CTR_W'(lim))
                  && (dy < dhc_pkg::CTR_W'(lim));

    always_comb begin
        probe_next = probe_in;
        if (hit && (probe_in.count != dhc_pkg::COUNT_MAX)) begin
            probe_next.count = probe_in.count + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sx_reg <= wr_cx2;
            sy_reg <= wr_cy2;
        end
        if (advance) begin
            probe_reg <= probe_next;
            fill_reg  <= fill_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= valid_in;
        end
    end

    assign valid_out = valid_reg;
    assign probe_out = probe_reg;
    assign fill_out  = fill_reg;

endmodule

// File: rtl/dwell_hotspot_counter_core.sv
// Dwell hotspot counter.
// Input channel s_*: one bounding box per transaction, newest box of the track
// first; s_track_start begins a new track and empties the centre store.
// Result channel m_*: at most one hotspot per box, sent when more stored
// centres than min_count lie strictly within radius of the box centre on
// both axes. Boxes that give no hotspot produce no result transaction.
// Config: APB, radius at 0x0, min_count at 0x4; write only while idle.
// The store is a chain of TRACK_DEPTH cells, one centre per cell. A query
// enters cell 0 and moves one cell per cycle while the chain is not held,
// each cell adding its own match to the running count; the new centre is
// written into its cell at acceptance. A query passes each cell register and
// then the result register; one box can be taken every cycle unless a result waits.
// Reset empties the store, clears overflow and loads radius 50, min_count
// 125; the store contents themselves are not cleared, nothing to wait for.
// When the receiver stalls with a result held, the whole chain holds and
// s_ready drops until the result transaction completes.
module dwell_hotspot_counter_core #(
    parameter int TRACK_DEPTH = dhc_pkg::TRACK_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // box input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [dhc_pkg::BOX_W-1:0]           s_box_x,
    input  logic [dhc_pkg::BOX_W-1:0]           s_box_y,
    input  logic [dhc_pkg::BOX_W-1:0]           s_box_width,
    input  logic [dhc_pkg::BOX_W-1:0]           s_box_height,
    input  logic                                s_track_start,
    // hotspot output
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dhc_pkg::HOT_W-1:0]           m_hot_x,
    output logic [dhc_pkg::HOT_W-1:0]           m_hot_y,
    output logic [dhc_pkg::COUNT_W-1:0]         m_hit_count,
    output logic [dhc_pkg::RADIUS_W-1:0]        m_ring_radius,
    output logic                                m_overflow,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dhc_pkg::PADDR_W-1:0]         paddr,
    input  logic [dhc_pkg::PDATA_W-1:0]         pwdata,
    output logic [dhc_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);

    localparam int FILL_W = $clog2(TRACK_DEPTH + 1);

    // Configuration registers
    logic [dhc_pkg::RADIUS_W-1:0] radius_reg;
    logic [dhc_pkg::COUNT_W-1:0]  min_count_reg;
    logic                         cfg_wr;

    // Track state
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic [FILL_W-1:0] fill_eff;
    logic              room;

    // Chain
    logic                      advance;
    logic                      accept;
    logic [dhc_pkg::CTR_W-1:0] cx2;
    logic [dhc_pkg::CTR_W-1:0] cy2;
    logic [dhc_pkg::RADIUS_W:0] lim;
    logic                      valid_chain [0:TRACK_DEPTH];
    dhc_pkg::probe_t           probe_chain [0:TRACK_DEPTH];
    logic [FILL_W-1:0]         fill_chain  [0:TRACK_DEPTH];

    // Output register
    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic [dhc_pkg::HOT_W-1:0]    hot_x_reg;
    logic [dhc_pkg::HOT_W-1:0]    hot_y_reg;
    logic [dhc_pkg::COUNT_W-1:0]  hit_count_reg;
    logic [dhc_pkg::RADIUS_W-1:0] ring_radius_reg;
    logic                         overflow_reg;
    logic                         hot;
    logic [dhc_pkg::CTR_W:0]      sum_x;
    logic [dhc_pkg::CTR_W:0]      sum_y;
    dhc_pkg::probe_t              tail;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg    <= dhc_pkg::RADIUS_RST;
            min_count_reg <= dhc_pkg::MIN_COUNT_RST;
        end else if (cfg_wr) begin
            unique case (paddr)
                dhc_pkg::ADDR_RADIUS: begin
                    radius_reg <= pwdata[dhc_pkg::RADIUS_W-1:0];
                end
                dhc_pkg::ADDR_MIN_COUNT: begin
                    min_count_reg <= pwdata[dhc_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            dhc_pkg::ADDR_RADIUS:    prdata = dhc_pkg::PDATA_W'(radius_reg);
            dhc_pkg::ADDR_MIN_COUNT: prdata = dhc_pkg::PDATA_W'(min_count_reg);
            default:                 prdata = '0;
        endcase
    end

    // ---------------- admission ----------------
    // Hold the chain and the input while a result waits on the receiver
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && advance;

    // Doubled centres: 2*edge + size
    assign cx2 = {1'b0, s_box_x, 1'b0} + {2'b00, s_box_width};
    assign cy2 = {1'b0, s_box_y, 1'b0} + {2'b00, s_box_height};
    assign lim = {radius_reg, 1'b0};

    // A new track drops all stored centres and the overflow mark
    assign fill_eff = s_track_start ? '0 : fill_reg;
    assign room     = fill_eff < FILL_W'(TRACK_DEPTH);

    always_comb begin
        fill_next = fill_reg;
        ovf_next  = ovf_reg;
        if (accept) begin
            fill_next = room ? fill_eff + 1'b1 : fill_eff;
            ovf_next  = (s_track_start ? 1'b0 : ovf_reg) | !room;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            ovf_reg  <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            ovf_reg  <= ovf_next;
        end
    end

    // ---------------- cell chain ----------------
    assign valid_chain[0]          = accept;
    assign probe_chain[0].cx2      = cx2;
    assign probe_chain[0].cy2      = cy2;
    assign probe_chain[0].count    = '0;
    assign probe_chain[0].overflow = ovf_next;
    assign fill_chain[0]           = fill_eff;

    for (genvar i = 0; i < TRACK_DEPTH; i++) begin : g_cell
        logic wr_en;

        // Store the new centre in the first free cell
        assign wr_en = accept && room && (fill_eff == FILL_W'(i));

        dhc_cell #(
            .FILL_W     (FILL_W),
            .CELL_INDEX (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .wr_en     (wr_en),
            .wr_cx2    (cx2),
            .wr_cy2    (cy2),
            .lim       (lim),
            .valid_in  (valid_chain[i]),
            .probe_in  (probe_chain[i]),
            .fill_in   (fill_chain[i]),
            .valid_out (valid_chain[i+1]),
            .probe_out (probe_chain[i+1]),
            .fill_out  (fill_chain[i+1])
        );
    end

    // ---------------- result stage ----------------
    assign tail  = probe_chain[TRACK_DEPTH];
    assign hot   = valid_chain[TRACK_DEPTH] && (tail.count > min_count_reg);
    assign sum_x = {1'b0, tail.cx2} + (dhc_pkg::CTR_W + 1)'(radius_reg);
    assign sum_y = {1'b0, tail.cy2} + (dhc_pkg::CTR_W + 1)'(radius_reg);

    assign m_valid_next = advance ? hot : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            hot_x_reg       <= sum_x[dhc_pkg::HOT_W:1];
            hot_y_reg       <= sum_y[dhc_pkg::HOT_W:1];
            hit_count_reg   <= tail.count;
            ring_radius_reg <= radius_reg;
            overflow_reg    <= tail.overflow;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_hot_x       = hot_x_reg;
    assign m_hot_y       = hot_y_reg;
    assign m_hit_count   = hit_count_reg;
    assign m_ring_radius = ring_radius_reg;
    assign m_overflow    = overflow_reg;

endmodule

// File: bench/dwell_hotspot_counter_core_tb.sv
`timescale 1ns / 1ps

module dwell_hotspot_counter_core_tb;

    localparam int BOX_W    = dhc_pkg::BOX_W;
    localparam int HOT_W    = dhc_pkg::HOT_W;
    localparam int COUNT_W  = dhc_pkg::COUNT_W;
    localparam int RADIUS_W = dhc_pkg::RADIUS_W;
    localparam int PADDR_W  = dhc_pkg::PADDR_W;
    localparam int PDATA_W  = dhc_pkg::PDATA_W;
    localparam logic [PADDR_W-1:0] ADDR_RADIUS    = dhc_pkg::ADDR_RADIUS;
    localparam logic [PADDR_W-1:0] ADDR_MIN_COUNT = dhc_pkg::ADDR_MIN_COUNT;

    localparam int DEPTH       = dhc_pkg::TRACK_DEPTH_DEF;
    localparam int BOX_MAX     = (1 << BOX_W) - 1;
    // Receiver hold-off: well past the chain length so the chain fills and s_ready drops
    localparam int HOLD_CYCLES = 700;

    // One box as it crosses the input channel
    typedef struct {
        logic [BOX_W-1:0] x;
        logic [BOX_W-1:0] y;
        logic [BOX_W-1:0] w;
        logic [BOX_W-1:0] h;
        logic             start;
    } box_t;

    // One hotspot as it crosses the result channel
    typedef struct {
        logic [HOT_W-1:0]    hot_x;
        logic [HOT_W-1:0]    hot_y;
        logic [COUNT_W-1:0]  hit_count;
        logic [RADIUS_W-1:0] ring_radius;
        logic                overflow;
    } hotspot_t;

    // Track the block's centre store and registers; queue the hotspots it must emit.
    class hotspot_scoreboard;
        int                  kept_x [DEPTH];
        int                  kept_y [DEPTH];
        int                  kept_n;
        bit                  overflowed;
        logic [RADIUS_W-1:0] radius;
        logic [COUNT_W-1:0]  min_count;
        hotspot_t            hotspots_due [$];
        int                  errors;

        function new();
            kept_n     = 0;
            overflowed = 1'b0;
            radius     = dhc_pkg::RADIUS_RST;
            min_count  = dhc_pkg::MIN_COUNT_RST;
            errors     = 0;
        endfunction

        function void set_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
            case (addr)
                ADDR_RADIUS:    radius    = data[RADIUS_W-1:0];
                ADDR_MIN_COUNT: min_count = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return hotspots_due.size();
        endfunction

        // Work out the hotspot (if any) that an accepted box causes.
        function void note_box(box_t b);
            int       cx;
            int       cy;
            int       lim;
            int       dx;
            int       dy;
            int       hits;
            hotspot_t hs;
            cx   = 2 * int'(b.x) + int'(b.w);
            cy   = 2 * int'(b.y) + int'(b.h);
            lim  = 2 * int'(radius);
            hits = 0;
            if (b.start) begin
                kept_n     = 0;
                overflowed = 1'b0;
            end
            for (int i = 0; i < kept_n; i++) begin
                dx = (cx >= kept_x[i]) ? cx - kept_x[i] : kept_x[i] - cx;
                dy = (cy >= kept_y[i]) ? cy - kept_y[i] : kept_y[i] - cy;
                if (dx < lim && dy < lim && hits < int'(dhc_pkg::COUNT_MAX))
                    hits++;
            end
            if (kept_n < DEPTH) begin
                kept_x[kept_n] = cx;
                kept_y[kept_n] = cy;
                kept_n++;
            end else begin
                overflowed = 1'b1;
            end
            if (hits > int'(min_count)) begin
                hs.hot_x       = HOT_W'((cx + int'(radius)) >> 1);
                hs.hot_y       = HOT_W'((cy + int'(radius)) >> 1);
                hs.hit_count   = COUNT_W'(hits);
                hs.ring_radius = radius;
                hs.overflow    = overflowed;
                hotspots_due = {hotspots_due, hs};
            end
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_hotspot(hotspot_t got);
            hotspot_t want;
            if (hotspots_due.size() == 0) begin
                report($sformatf("unexpected hotspot x=%0d y=%0d count=%0d",
                                 got.hot_x, got.hot_y, got.hit_count));
                return;
            end
            want = hotspots_due.pop_front();
            if (got.hot_x !== want.hot_x)
                report($sformatf("hot_x got %0d want %0d", got.hot_x, want.hot_x));
            if (got.hot_y !== want.hot_y)
                report($sformatf("hot_y got %0d want %0d", got.hot_y, want.hot_y));
            if (got.hit_count !== want.hit_count)
                report($sformatf("hit_count got %0d want %0d",
                                 got.hit_count, want.hit_count));
            if (got.ring_radius !== want.ring_radius)
                report($sformatf("ring_radius got %0d want %0d",
                                 got.ring_radius, want.ring_radius));
            if (got.overflow !== want.overflow)
                report($sformatf("overflow got %0b want %0b", got.overflow, want.overflow));
        endtask
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [BOX_W-1:0]    s_box_x;
    logic [BOX_W-1:0]    s_box_y;
    logic [BOX_W-1:0]    s_box_width;
    logic [BOX_W-1:0]    s_box_height;
    logic                s_track_start;
    logic                m_valid;
    logic                m_ready;
    logic [HOT_W-1:0]    m_hot_x;
    logic [HOT_W-1:0]    m_hot_y;
    logic [COUNT_W-1:0]  m_hit_count;
    logic [RADIUS_W-1:0] m_ring_radius;
    logic                m_overflow;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    hotspot_scoreboard sb = new();

    // Idle percentages per side, and the request for one long receiver hold-off
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off_req;

    dwell_hotspot_counter_core #(
        .TRACK_DEPTH(DEPTH)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_box_x      (s_box_x),
        .s_box_y      (s_box_y),
        .s_box_width  (s_box_width),
        .s_box_height (s_box_height),
        .s_track_start(s_track_start),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hot_x      (m_hot_x),
        .m_hot_y      (m_hot_y),
        .m_hit_count  (m_hit_count),
        .m_ring_radius(m_ring_radius),
        .m_overflow   (m_overflow),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 100 MHz clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Hard stop in case a handshake never completes
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Feed every accepted box to the predictor. Sample at the edge, before any
    // nonblocking update lands, so the values seen are the ones the block saw.
    always @(posedge aclk) begin
        box_t b;
        if (aresetn === 1'b1 && s_valid && s_ready) begin
            b.x     = s_box_x;
            b.y     = s_box_y;
            b.w     = s_box_width;
            b.h     = s_box_height;
            b.start = s_track_start;
            sb.note_box(b);
        end
    end

    // Check every hotspot transaction against the oldest one due.
    always @(posedge aclk) begin
        hotspot_t got;
        if (aresetn === 1'b1 && m_valid && m_ready) begin
            got.hot_x       = m_hot_x;
            got.hot_y       = m_hot_y;
            got.hit_count   = m_hit_count;
            got.ring_radius = m_ring_radius;
            got.overflow    = m_overflow;
            sb.check_hotspot(got);
        end
    end

    // Result receiver: stall at the current idle rate; on request, hold off for
    // a long stretch counted here while the sender keeps pushing boxes.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge aclk);
                hold_off_req = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Clamp a pixel coordinate into the box field range.
    function automatic logic [BOX_W-1:0] clamp_px(int v);
        if (v < 0)
            return '0;
        if (v > BOX_MAX)
            return BOX_W'(BOX_MAX);
        return v[BOX_W-1:0];
    endfunction

    // Offer one box, idling first at the sender's rate; return at the edge of acceptance.
    task automatic send_box(logic [BOX_W-1:0] x, logic [BOX_W-1:0] y,
                            logic [BOX_W-1:0] w, logic [BOX_W-1:0] h, logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_box_x       <= x;
        s_box_y       <= y;
        s_box_width   <= w;
        s_box_height  <= h;
        s_track_start <= start;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle; the register takes it at the end of the access cycle.
    task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(addr, data);
    endtask

    // Drop valid, wait for every due hotspot, then let the chain run empty:
    // boxes that give no hotspot may still be travelling down it.
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DEPTH + 16) @(posedge aclk);
    endtask

    // One track: boxes scattered around a random spot, first box starts the track.
    // A share of the boxes is pure noise, some of them cutting the track short.
    task automatic run_track(int len, int spread, int noise_pct);
        int tx;
        int ty;
        int bw;
        int bh;
        int wj;
        int w;
        int h;
        tx = $urandom_range(0, BOX_MAX);
        ty = $urandom_range(0, BOX_MAX);
        bw = $urandom_range(0, BOX_MAX) >> $urandom_range(0, BOX_W);
        bh = $urandom_range(0, BOX_MAX) >> $urandom_range(0, BOX_W);
        wj = (spread < 3) ? spread : 3;
        for (int k = 0; k < len; k++) begin
            if (k > 0 && $urandom_range(99) < noise_pct) begin
                send_box(BOX_W'($urandom_range(0, BOX_MAX)),
                         BOX_W'($urandom_range(0, BOX_MAX)),
                         BOX_W'($urandom_range(0, BOX_MAX)),
                         BOX_W'($urandom_range(0, BOX_MAX)),
                         $urandom_range(9) == 0);
            end else begin
                w = bw + int'($urandom_range(0, 2 * wj)) - wj;
                h = bh + int'($urandom_range(0, 2 * wj)) - wj;
                send_box(clamp_px(tx - w / 2 + int'($urandom_range(0, 2 * spread)) - spread),
                         clamp_px(ty - h / 2 + int'($urandom_range(0, 2 * spread)) - spread),
                         clamp_px(w), clamp_px(h), k == 0);
            end
        end
    endtask

    // Back-to-back tracks of random length and spread until the item budget is spent.
    task automatic run_tracks(int total, int max_len);
        int sent;
        int len;
        sent = 0;
        while (sent < total) begin
            len = $urandom_range(2, max_len);
            if (len > total - sent)
                len = total - sent;
            run_track(len, $urandom_range(0, int'(sb.radius)), 8);
            sent += len;
        end
    endtask

    initial begin
        s_valid       <= 1'b0;
        s_box_x       <= '0;
        s_box_y       <= '0;
        s_box_width   <= '0;
        s_box_height  <= '0;
        s_track_start <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        hold_off_req  = 1'b0;
        send_idle_pct = 6;
        recv_idle_pct = 76;

        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: smallest nonzero radius, any neighbour makes a hotspot
        write_reg(ADDR_RADIUS, 1);
        write_reg(ADDR_MIN_COUNT, 0);
        send_box(0, 0, 0, 0, 1'b1);
        send_box(0, 0, 0, 0, 1'b0);
        send_box(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1);
        send_box(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0);
        // Half-pixel steps: one apart counts, two apart does not
        send_box(10, 10, 0, 0, 1'b1);
        send_box(10, 10, 1, 0, 1'b0);
        send_box(10, 10, 2, 0, 1'b0);
        send_box(10, 11, 2, 0, 1'b0);
        send_box(0, 12'hFFF, 12'hFFF, 0, 1'b1);
        send_box(12'hFFF, 0, 0, 12'hFFF, 1'b0);
        settle();

        // Zero radius: identical centres still never count
        write_reg(ADDR_RADIUS, 0);
        send_box(5, 5, 5, 5, 1'b1);
        send_box(5, 5, 5, 5, 1'b0);
        send_box(5, 5, 5, 5, 1'b0);
        settle();

        // Threshold 256 with the largest radius: these four boxes cannot get past it
        write_reg(ADDR_RADIUS, 255);
        write_reg(ADDR_MIN_COUNT, 256);
        send_box(7, 9, 3, 3, 1'b1);
        send_box(7, 9, 3, 3, 1'b0);
        send_box(8, 9, 3, 3, 1'b0);
        send_box(7, 10, 3, 3, 1'b0);
        settle();

        // Largest radius at its edge: 508 doubled apart counts, 511 does not
        write_reg(ADDR_MIN_COUNT, 0);
        send_box(100, 100, 0, 0, 1'b1);
        send_box(354, 100, 0, 0, 1'b0);
        send_box(355, 100, 1, 0, 1'b0);
        settle();

        // Reset values again: a long tight track has to pass 125 neighbours
        write_reg(ADDR_RADIUS, 50);
        write_reg(ADDR_MIN_COUNT, 125);
        run_track(150, 10, 0);
        settle();

        write_reg(ADDR_RADIUS, 20);
        write_reg(ADDR_MIN_COUNT, 3);
        run_tracks(250, 60);
        settle();

        // Swap the idle rates; hold the receiver off while boxes keep coming
        send_idle_pct = 76;
        recv_idle_pct = 6;
        write_reg(ADDR_RADIUS, 255);
        write_reg(ADDR_MIN_COUNT, 10);
        hold_off_req = 1'b1;
        run_tracks(200, 50);
        settle();

        // Overflow: one track longer than the store, every box near the others
        write_reg(ADDR_RADIUS, 8);
        write_reg(ADDR_MIN_COUNT, 1);
        run_track(280, 2, 0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_tracks(60, 40);
        settle();

        write_reg(ADDR_RADIUS, 1);
        write_reg(ADDR_MIN_COUNT, 0);
        run_tracks(150, 40);
        settle();

        write_reg(ADDR_RADIUS, 100);
        write_reg(ADDR_MIN_COUNT, 256);
        run_tracks(80, 40);
        settle();

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
